@@ src/wss_pkg.sv @@
package wss_pkg;

    // Widths fixed by the register map and the transaction fields.
    localparam int MAX_PATTERN_BYTES_DEF = 24;
    localparam int PAT_REG_BYTES         = 24;
    localparam int PAT_BITS              = 8 * PAT_REG_BYTES;
    localparam int LEN_W                 = 5;
    localparam int WORD_W                = 32;
    localparam int APB_DATA_W            = 64;
    localparam int APB_ADDR_W            = 6;
    localparam int MIN_LENGTH            = 5;
    localparam int DISP_BYTES            = 4;

    // Register indexes, at byte address 8 * index.
    localparam logic [2:0] REG_PAT_LOW  = 3'd0;
    localparam logic [2:0] REG_PAT_MID  = 3'd1;
    localparam logic [2:0] REG_PAT_HIGH = 3'd2;
    localparam logic [2:0] REG_LENGTH   = 3'd3;
    localparam logic [2:0] REG_CODE_OFS = 3'd4;

    typedef enum logic [1:0] {
        ST_NOT_FOUND = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NO_SLOT   = 2'd2
    } t_status;

    typedef struct packed {
        logic [PAT_BITS-1:0] pattern;
        logic [LEN_W-1:0]    length;
        logic [WORD_W-1:0]   code_offset;
    } t_cfg;

    // What every cell of the window needs to know about the pattern in use.
    typedef struct packed {
        logic [PAT_BITS-1:0] pattern;
        logic [LEN_W-1:0]    eff_len;
        logic [LEN_W-1:0]    slot;
    } t_cell_ctl;

    // Pattern byte at an index; bytes beyond the registers read as zero.
    function automatic logic [7:0] pat_byte(input logic [PAT_BITS-1:0] pat,
                                            input logic [LEN_W-1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        for (int n = 0; n < PAT_REG_BYTES; n++) begin
            if (int'(idx) == n) begin
                b = pat[8*n +: 8];
            end
        end
        return b;
    endfunction

endpackage

@@ src/wss_if.sv @@
interface wss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface wss_out_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic [wss_pkg::WORD_W-1:0] match_position;
    logic [wss_pkg::WORD_W-1:0] resolved_address;

    modport source (output valid, output status, output match_position,
                    output resolved_address, input ready);
    modport sink   (input valid, input status, input match_position,
                    input resolved_address, output ready);
endinterface

@@ src/wss_cfg.sv @@
module wss_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wss_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [wss_pkg::APB_DATA_W-1:0] pwdata,
    output logic [wss_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output wss_pkg::t_cfg                  o_cfg
);

    logic [63:0]                r_pat_low;
    logic [63:0]                r_pat_mid;
    logic [63:0]                r_pat_high;
    logic [wss_pkg::LEN_W-1:0]  r_length;
    logic [wss_pkg::WORD_W-1:0] r_code_ofs;
    logic [2:0]                 reg_idx;
    logic                       wr_en;

    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_mid  <= '0;
            r_pat_high <= '0;
            r_length   <= wss_pkg::LEN_W'(wss_pkg::MIN_LENGTH);
            r_code_ofs <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                wss_pkg::REG_PAT_LOW:  r_pat_low  <= pwdata;
                wss_pkg::REG_PAT_MID:  r_pat_mid  <= pwdata;
                wss_pkg::REG_PAT_HIGH: r_pat_high <= pwdata;
                wss_pkg::REG_LENGTH:   r_length   <= pwdata[wss_pkg::LEN_W-1:0];
                wss_pkg::REG_CODE_OFS: r_code_ofs <= pwdata[wss_pkg::WORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            wss_pkg::REG_PAT_LOW:  prdata = r_pat_low;
            wss_pkg::REG_PAT_MID:  prdata = r_pat_mid;
            wss_pkg::REG_PAT_HIGH: prdata = r_pat_high;
            wss_pkg::REG_LENGTH:   prdata = 64'(r_length);
            wss_pkg::REG_CODE_OFS: prdata = 64'(r_code_ofs);
            default:               prdata = '0;
        endcase
    end

    assign o_cfg.pattern     = {r_pat_high, r_pat_mid, r_pat_low};
    assign o_cfg.length      = r_length;
    assign o_cfg.code_offset = r_code_ofs;

endmodule

@@ src/wss_cell.sv @@
module wss_cell #(
    parameter int MAX_PATTERN_BYTES = wss_pkg::MAX_PATTERN_BYTES_DEF,
    parameter int IDX               = 0
) (
    input  logic                       i_clk,
    input  logic                       i_shift,
    input  logic [7:0]                 i_byte,
    input  wss_pkg::t_cell_ctl         i_ctl,
    output logic [7:0]                 o_byte,
    output logic                       o_ok,
    output logic [wss_pkg::WORD_W-1:0] o_disp
);

    // Distance of this cell from the newest byte of the window.
    localparam int DIST = MAX_PATTERN_BYTES - 1 - IDX;
    localparam int DW   = $clog2(MAX_PATTERN_BYTES);
    localparam int CW   = ((DW > wss_pkg::LEN_W) ? DW : wss_pkg::LEN_W) + 1;
    localparam logic [CW-1:0] DIST_C = CW'(DIST);

    logic [7:0]                r_byte;
    logic [CW-1:0]             len_c;
    logic [CW-1:0]             pidx_c;
    logic [wss_pkg::LEN_W-1:0] pidx;
    logic [wss_pkg::LEN_W-1:0] rel;
    logic [7:0]                pbyte;
    logic                      active;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

    // The cell judges the byte it is about to take, so the comparison sees
    // the window as it stands after this transaction.
    always_comb begin
        len_c  = CW'(i_ctl.eff_len);
        active = len_c > DIST_C;
        pidx_c = len_c - CW'(1) - DIST_C;
        pidx   = pidx_c[wss_pkg::LEN_W-1:0];
        rel    = pidx - i_ctl.slot;
        pbyte  = wss_pkg::pat_byte(i_ctl.pattern, pidx);
        o_ok   = 1'b1;
        o_disp = '0;
        if (active) begin
            if (pidx == '0) begin
                o_ok = (i_byte == pbyte);
            end else begin
                o_ok = (pbyte == 8'h00) || (i_byte == pbyte);
            end
            if (i_ctl.slot != '0 && rel < wss_pkg::LEN_W'(wss_pkg::DISP_BYTES)) begin
                o_disp = {24'h000000, i_byte} << {rel[1:0], 3'b000};
            end
        end
    end

endmodule

@@ src/wildcard_signature_scan_core.sv @@
// Streaming wildcard signature scanner. Bytes of a file enter one per
// transaction on i_in, and the last one is flagged by last_byte. The window is
// a chain of byte cells, one per pattern position up to MAX_PATTERN_BYTES;
// every cell shifts its byte to its neighbour on each accepted transaction and
// compares it against the pattern byte that lines up with it, so a new byte
// can be accepted in every clock cycle while the result stages have room,
// whatever the pattern length. Pattern byte zero must match exactly; a later
// zero pattern byte matches anything, and the first such byte among positions
// 1 to length-4 marks a 32-bit little-endian displacement. At most one result
// transaction leaves o_out per file: found (with the window start and the
// resolved address), no displacement slot, or not found on the last byte. The
// judging stage registers the verdict on the window, then the output register
// adds the displacement and code offset. The output register and the judging
// stage let the input keep flowing while a result waits for o_out.ready.
// After the last byte the scanner re-arms for the next file. Registers sit on
// an APB port at byte address 8 * index, 64 bits each, and should be written
// only while the scanner has nothing in flight.
module wildcard_signature_scan_core #(
    parameter int MAX_PATTERN_BYTES = wss_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    wss_in_if.sink                         i_in,
    wss_out_if.source                      o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wss_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [wss_pkg::APB_DATA_W-1:0] pwdata,
    output logic [wss_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam int LW = wss_pkg::LEN_W;
    localparam int WW = wss_pkg::WORD_W;
    // Longest pattern the length register can ask for on this window.
    localparam int LEN_MAX = (MAX_PATTERN_BYTES < (1 << LW) - 1) ?
                             MAX_PATTERN_BYTES : (1 << LW) - 1;
    localparam logic [LW-1:0] LEN_CAP = LW'(LEN_MAX);
    localparam logic [LW-1:0] LEN_MIN = LW'(wss_pkg::MIN_LENGTH);

    wss_pkg::t_cfg      cfg;
    wss_pkg::t_cell_ctl ctl;

    // Scan state.
    logic [WW-1:0] r_count;
    logic [WW-1:0] n_count;
    logic          r_done;
    logic          n_done;

    // Judging stage.
    logic             r_a_valid;
    wss_pkg::t_status r_a_status;
    logic [WW-1:0]    r_a_mpos;
    logic [WW-1:0]    r_a_rel;
    logic [WW-1:0]    r_a_disp;

    // Output register.
    logic             r_b_valid;
    wss_pkg::t_status r_b_status;
    logic [WW-1:0]    r_b_mpos;
    logic [WW-1:0]    r_b_addr;

    logic [7:0]    cell_byte [MAX_PATTERN_BYTES];
    logic [7:0]    cell_in   [MAX_PATTERN_BYTES];
    logic [WW-1:0] cell_disp [MAX_PATTERN_BYTES];
    logic [MAX_PATTERN_BYTES-1:0] cell_ok;

    logic          acc;
    logic          a_adv;
    logic          b_adv;
    logic [LW-1:0] eff_len;
    logic [LW-1:0] slot;
    logic [WW-1:0] disp;
    logic [WW-1:0] mpos;
    logic [WW-1:0] rel;
    logic [LW:0]   rel_delta;
    logic          full;
    logic          hit;
    logic          emit;
    wss_pkg::t_status status;

    wss_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Effective length and the displacement slot follow from the registers
    // alone. The slot is the first wildcard among positions 1 to length-4;
    // pattern bytes past the registers count as wildcards.
    always_comb begin
        if (cfg.length < LEN_MIN) begin
            eff_len = LEN_MIN;
        end else if (cfg.length > LEN_CAP) begin
            eff_len = LEN_CAP;
        end else begin
            eff_len = cfg.length;
        end
        slot = '0;
        for (int k = (1 << LW) - 1 - wss_pkg::DISP_BYTES; k >= 1; k--) begin
            if (k + wss_pkg::DISP_BYTES <= int'(eff_len) &&
                wss_pkg::pat_byte(cfg.pattern, LW'(k)) == 8'h00) begin
                slot = LW'(k);
            end
        end
    end

    assign ctl.pattern = cfg.pattern;
    assign ctl.eff_len = eff_len;
    assign ctl.slot    = slot;

    // The window: the newest byte enters the last cell and moves one cell
    // towards index zero on every accepted transaction.
    for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_cell
        if (j == MAX_PATTERN_BYTES - 1) begin : g_head
            assign cell_in[j] = i_in.byte_value;
        end else begin : g_body
            assign cell_in[j] = cell_byte[j+1];
        end
        wss_cell #(
            .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
            .IDX               (j)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (acc),
            .i_byte  (cell_in[j]),
            .i_ctl   (ctl),
            .o_byte  (cell_byte[j]),
            .o_ok    (cell_ok[j]),
            .o_disp  (cell_disp[j])
        );
    end

    // Flow control: each stage moves when the one after it is empty or
    // draining, so the input stays open while a result waits downstream.
    assign b_adv      = !r_b_valid || o_out.ready;
    assign a_adv      = !r_a_valid || b_adv;
    assign i_in.ready = a_adv;
    assign acc        = i_in.valid && a_adv;

    always_comb begin
        disp = '0;
        for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
            disp = disp | cell_disp[j];
        end
        // The window holds a full pattern once length bytes of this file
        // have arrived, counting the one now entering.
        full = r_count >= (WW'(eff_len) - WW'(1));
        hit  = !r_done && full && (&cell_ok);
        emit = hit || (i_in.last_byte && !r_done);
        mpos = r_count - (WW'(eff_len) - WW'(1));
        // Window start plus slot plus four, folded into one small offset.
        rel_delta = {1'b0, slot} + (LW+1)'(wss_pkg::DISP_BYTES + 1) - {1'b0, eff_len};
        rel       = r_count + {{(WW-LW-1){rel_delta[LW]}}, rel_delta};
        if (hit) begin
            status = (slot == '0) ? wss_pkg::ST_NO_SLOT : wss_pkg::ST_FOUND;
        end else begin
            status = wss_pkg::ST_NOT_FOUND;
        end
        if (i_in.last_byte) begin
            n_count = '0;
            n_done  = 1'b0;
        end else begin
            n_count = r_count + WW'(1);
            n_done  = r_done || hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_done    <= 1'b0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_count <= n_count;
                r_done  <= n_done;
            end
            if (a_adv) begin
                r_a_valid <= acc && emit;
            end
            if (b_adv) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_a_status <= status;
            r_a_mpos   <= hit ? mpos : '0;
            r_a_rel    <= rel;
            r_a_disp   <= disp;
        end
        if (b_adv) begin
            r_b_status <= r_a_status;
            r_b_mpos   <= r_a_mpos;
            r_b_addr   <= (r_a_status == wss_pkg::ST_FOUND) ?
                          (r_a_rel + r_a_disp + cfg.code_offset) : '0;
        end
    end

    assign o_out.valid            = r_b_valid;
    assign o_out.status           = r_b_status;
    assign o_out.match_position   = r_b_mpos;
    assign o_out.resolved_address = r_b_addr;

    // The last byte of a file always re-arms the scan.
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_in.last_byte |=> r_count == '0 && !r_done)
        else $error("scan did not re-arm after the last byte");

    // Once a file has produced its result, no further byte may raise one.
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && r_done && !i_in.last_byte |=> !r_a_valid)
        else $error("second result raised for one file");

    // Only a found result carries an address; not found carries no position.
    a_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status != wss_pkg::ST_FOUND |-> o_out.resolved_address == '0)
        else $error("address on a result that was not found");

    a_nf_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status == wss_pkg::ST_NOT_FOUND |-> o_out.match_position == '0)
        else $error("position on a not-found result");

    // An empty judging stage never blocks the input.
    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_a_valid |-> i_in.ready)
        else $error("input stalled with the judging stage empty");

endmodule

@@ tb/sv/wss_scan_checker.sv @@
// Watches the byte channel, the result channel and register writes on the
// APB port, predicts the report of every file and compares the results.
module wss_scan_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    wss_in_if                              i_in,
    wss_out_if                             i_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [wss_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [wss_pkg::APB_DATA_W-1:0] pwdata,
    output int                             o_mismatches,
    output int                             o_pending,
    output int                             o_found,
    output int                             o_no_slot,
    output int                             o_not_found
);
    timeunit 1ns;
    timeprecision 1ps;
    import wss_pkg::*;

    localparam int WIN_BYTES = MAX_PATTERN_BYTES_DEF;

    typedef struct packed {
        t_status             status;
        logic [WORD_W-1:0]   position;
        logic [WORD_W-1:0]   address;
    } t_scan_report;

    // Our own copy of the registers.
    logic [PAT_BITS-1:0] pat_q;
    logic [LEN_W-1:0]    len_q;
    logic [WORD_W-1:0]   ofs_q;

    // Scan state of the file in progress.
    logic [7:0]          win [WIN_BYTES];
    logic [WORD_W-1:0]   byte_pos;
    logic                scan_done;

    t_scan_report        report_q [$];
    int                  fail_total;
    int                  n_found;
    int                  n_no_slot;
    int                  n_not_found;

    assign o_mismatches = fail_total;
    assign o_found      = n_found;
    assign o_no_slot    = n_no_slot;
    assign o_not_found  = n_not_found;

    function automatic logic [7:0] pat_at(input int idx);
        return pat_q[8*idx +: 8];
    endfunction

    task automatic clear_scan();
        for (int k = 0; k < WIN_BYTES; k++) win[k] = 8'h00;
        byte_pos  = '0;
        scan_done = 1'b0;
    endtask

    task automatic note_fail(input string msg);
        if (fail_total < 10) $display("%s", msg);
        fail_total++;
    endtask

    // Shifts one byte into the window and queues the report it causes, if any.
    task automatic predict_byte(input logic [7:0] value, input logic is_last);
        int              eff;
        int              base;
        int              slot;
        logic            hit;
        logic [WORD_W-1:0] pos;
        logic [WORD_W-1:0] disp;
        t_scan_report    rep;
        eff = int'(len_q);
        if (eff < MIN_LENGTH) eff = MIN_LENGTH;
        if (eff > WIN_BYTES) eff = WIN_BYTES;
        base = WIN_BYTES - eff;
        for (int k = 0; k < WIN_BYTES - 1; k++) win[k] = win[k+1];
        win[WIN_BYTES-1] = value;
        pos      = byte_pos;
        byte_pos = pos + 32'd1;

        if (!scan_done && pos >= 32'(eff - 1)) begin
            hit = (win[base] == pat_at(0));
            for (int k = 1; k < eff; k++) begin
                if (pat_at(k) != 8'h00 && win[base+k] != pat_at(k)) hit = 1'b0;
            end
            if (hit) begin
                // The slot is the first wildcard that leaves room for four bytes.
                slot = 0;
                for (int k = eff - 4; k >= 1; k--) begin
                    if (pat_at(k) == 8'h00) slot = k;
                end
                rep.position = pos - 32'(eff - 1);
                if (slot == 0) begin
                    rep.status  = ST_NO_SLOT;
                    rep.address = '0;
                end else begin
                    disp = {win[base+slot+3], win[base+slot+2],
                            win[base+slot+1], win[base+slot]};
                    rep.status  = ST_FOUND;
                    rep.address = rep.position + 32'(slot) + 32'(DISP_BYTES) + disp + ofs_q;
                end
                report_q.push_back(rep);
                scan_done = 1'b1;
            end
        end

        if (is_last) begin
            if (!scan_done) begin
                rep.status   = ST_NOT_FOUND;
                rep.position = '0;
                rep.address  = '0;
                report_q.push_back(rep);
            end
            clear_scan();
        end
    endtask

    task automatic check_report();
        t_scan_report want;
        if (report_q.size() == 0) begin
            note_fail($sformatf("unexpected result: status %0d position %h address %h",
                                i_out.status, i_out.match_position, i_out.resolved_address));
        end else begin
            want = report_q.pop_front();
            if (i_out.status !== want.status)
                note_fail($sformatf("status mismatch: expected %0d, got %0d",
                                    want.status, i_out.status));
            if (i_out.match_position !== want.position)
                note_fail($sformatf("match_position mismatch: expected %h, got %h",
                                    want.position, i_out.match_position));
            if (i_out.resolved_address !== want.address)
                note_fail($sformatf("resolved_address mismatch: expected %h, got %h",
                                    want.address, i_out.resolved_address));
            case (want.status)
                ST_FOUND:  n_found++;
                ST_NO_SLOT: n_no_slot++;
                default:   n_not_found++;
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pat_q       = '0;
            len_q       = LEN_W'(MIN_LENGTH);
            ofs_q       = '0;
            clear_scan();
            report_q.delete();
            fail_total  = 0;
            n_found     = 0;
            n_no_slot   = 0;
            n_not_found = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_ADDR_W-1:3])
                    REG_PAT_LOW:  pat_q[63:0]    = pwdata;
                    REG_PAT_MID:  pat_q[127:64]  = pwdata;
                    REG_PAT_HIGH: pat_q[191:128] = pwdata;
                    REG_LENGTH:   len_q          = pwdata[LEN_W-1:0];
                    REG_CODE_OFS: ofs_q          = pwdata[WORD_W-1:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) predict_byte(i_in.byte_value, i_in.last_byte);
            if (i_out.valid && i_out.ready) check_report();
        end
        o_pending <= report_q.size();
    end

endmodule

@@ tb/sv/wildcard_signature_scan_core_tb.sv @@
// Top level of the scanner testbench. It makes the byte stream, drives the
// register port and the result channel's ready, and gives the verdict; the
// checker beside the block does all prediction and comparison.
module wildcard_signature_scan_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wss_pkg::*;

    localparam int MAXB            = MAX_PATTERN_BYTES_DEF;
    localparam int PHASES          = 8;
    localparam int PRESSURE_PHASE  = 5;
    localparam int BYTES_PER_PHASE = 78;
    localparam int HOLD_CYCLES     = 160;
    // Results pass the block's judging and output registers; leave a margin.
    localparam int DRAIN_CYCLES    = 6;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic                  pready;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;

    wss_in_if  byte_ch ();
    wss_out_if report_ch ();

    int mismatches;
    int pending;
    int found_cnt;
    int no_slot_cnt;
    int not_found_cnt;

    // Shared between the stimulus and the result sink.
    bit hold_armed;
    bit hold_seen;
    bit quiet_tail;

    // The pattern currently loaded, so that files can be built around it.
    logic [PAT_BITS-1:0] pat_bits;
    int                  eff_len;
    logic [7:0]          file_bytes [$];
    int                  bytes_sent;
    int                  files_sent;
    int                  settings_used;

    wildcard_signature_scan_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (report_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    wss_scan_checker scan_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (byte_ch),
        .i_out        (report_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_found      (found_cnt),
        .o_no_slot    (no_slot_cnt),
        .o_not_found  (not_found_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Generous upper bound: several times the slowest legal run.
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // Result sink. It stalls in short random bursts, and once during the run
    // it holds ready low for a long stretch so that results pile up inside the
    // block and the byte channel is pushed back. Near the end it never stalls.
    initial begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        report_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_armed) begin
                hold_armed = 1'b0;
                hold_seen  = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                report_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                report_ch.ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 3);
                report_ch.ready <= 1'b0;
            end else begin
                report_ch.ready <= 1'b1;
            end
        end
    end

    function automatic int effective_length(input int len_raw);
        if (len_raw < MIN_LENGTH) return MIN_LENGTH;
        if (len_raw > MAXB) return MAXB;
        return len_raw;
    endfunction

    // Random pattern with about one zero (wildcard) byte in four. With a slot
    // wanted, one of positions 1 to length-4 is forced to zero; without, all of
    // them are made non-zero so that a match reports the missing slot.
    function automatic logic [PAT_BITS-1:0] make_pattern(input int eff, input bit want_slot);
        logic [PAT_BITS-1:0] p;
        for (int k = 0; k < PAT_REG_BYTES; k++)
            p[8*k +: 8] = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
        if (want_slot) begin
            p[8*$urandom_range(1, eff - 4) +: 8] = 8'h00;
        end else begin
            for (int k = 1; k <= eff - 4; k++)
                if (p[8*k +: 8] == 8'h00) p[8*k +: 8] = 8'($urandom_range(1, 255));
        end
        return p;
    endfunction

    // Filler byte: half of them are copies of pattern bytes, which makes
    // partial matches and near misses common.
    function automatic logic [7:0] noise_byte();
        if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
        return pat_bits[8*$urandom_range(0, eff_len - 1) +: 8];
    endfunction

    // Appends one occurrence of the pattern with fresh bytes in the wildcard
    // positions, which also gives a fresh displacement. A broken copy has one
    // exact-match position altered.
    function automatic void append_pattern(input bit broken);
        int         bad;
        logic [7:0] b;
        bad = broken ? $urandom_range(0, eff_len - 1) : -1;
        if (bad > 0 && pat_bits[8*bad +: 8] == 8'h00) bad = 0;
        for (int k = 0; k < eff_len; k++) begin
            b = pat_bits[8*k +: 8];
            if (k > 0 && b == 8'h00) b = 8'($urandom_range(0, 255));
            if (k == bad) b = b ^ 8'($urandom_range(1, 255));
            file_bytes.push_back(b);
        end
    endfunction

    // One byte transaction, with an occasional idle burst in front of it.
    task automatic send_byte(input logic [7:0] value, input logic is_last);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.byte_value <= value;
        byte_ch.last_byte  <= is_last;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Sends the bytes gathered in file_bytes as one file.
    task automatic send_queued();
        for (int k = 0; k < file_bytes.size(); k++)
            send_byte(file_bytes[k], k == file_bytes.size() - 1);
        file_bytes.delete();
        files_sent++;
    endtask

    task automatic stop_bytes();
        byte_ch.valid <= 1'b0;
    endtask

    // Mostly well-formed files: filler, the pattern, perhaps a second copy
    // that must be ignored, more filler. The rest are broken copies and noise.
    task automatic send_file(input bit keep_short);
        int kind;
        int pre;
        int post;
        int n;
        kind = $urandom_range(0, 9);
        pre  = keep_short ? 0 : $urandom_range(0, 6);
        post = keep_short ? 0 : $urandom_range(0, 4);
        if (kind >= 8) begin
            n = $urandom_range(1, keep_short ? 6 : 14);
            for (int k = 0; k < n; k++) file_bytes.push_back(noise_byte());
        end else begin
            for (int k = 0; k < pre; k++) file_bytes.push_back(noise_byte());
            append_pattern(kind == 7);
            if (!keep_short && $urandom_range(0, 3) == 0) append_pattern(1'b0);
            for (int k = 0; k < post; k++) file_bytes.push_back(noise_byte());
        end
        send_queued();
    endtask

    // Waits until every predicted result has come back and the block has had
    // time to finish any byte that causes none.
    task automatic settle();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Registers are only ever rewritten with the scanner idle between files.
    task automatic load_setting(input logic [PAT_BITS-1:0] pat, input int len_raw,
                                input logic [WORD_W-1:0] ofs);
        settle();
        write_reg(REG_PAT_LOW,  pat[63:0]);
        write_reg(REG_PAT_MID,  pat[127:64]);
        write_reg(REG_PAT_HIGH, pat[191:128]);
        write_reg(REG_LENGTH,   APB_DATA_W'(len_raw));
        write_reg(REG_CODE_OFS, APB_DATA_W'(ofs));
        pat_bits = pat;
        eff_len  = effective_length(len_raw);
        settings_used++;
    endtask

    initial begin : stimulus
        int                  len_raw;
        int                  phase_start;
        bit                  want_slot;
        logic [WORD_W-1:0]   ofs;
        logic [PAT_BITS-1:0] pat;

        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        byte_ch.valid      <= 1'b0;
        byte_ch.byte_value <= 8'h00;
        byte_ch.last_byte  <= 1'b0;
        pat_bits           = '0;
        eff_len            = MIN_LENGTH;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed files under the reset setting: an all-zero pattern of five
        // bytes, so any window that opens with zero matches and the slot is
        // at position one. The first file matches at offset zero on its final
        // byte, with extreme byte values in the displacement.
        file_bytes = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};
        send_queued();
        // Files too short to fill the window are not found, even all-zero ones.
        file_bytes = '{8'hFF, 8'hFF, 8'hFF};
        send_queued();
        file_bytes = '{8'h00, 8'h00, 8'h00};
        send_queued();
        // After the first match the rest of the file is ignored and the final
        // byte only re-arms the scanner.
        file_bytes = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h00, 8'h05, 8'h06};
        send_queued();
        stop_bytes();

        // A pattern without any zero byte: a match reports the missing slot.
        load_setting(PAT_BITS'(64'h0000_0094_9392_9190), MIN_LENGTH, 32'h0);
        file_bytes = '{8'h55, 8'h90, 8'h91, 8'h92, 8'h93, 8'h94};
        send_queued();
        stop_bytes();

        // Random phases, each under its own setting. The first four cover the
        // shortest and longest patterns, lengths beyond both ends of the legal
        // range, and the extreme code offsets.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:              len_raw = MIN_LENGTH;
                1:              len_raw = MAXB;
                2:              len_raw = (1 << LEN_W) - 1;
                3:              len_raw = 0;
                PRESSURE_PHASE: len_raw = MIN_LENGTH;
                default:        len_raw = $urandom_range(0, (1 << LEN_W) - 1);
            endcase
            if (phase == 0)
                ofs = '0;
            else if (phase == 1)
                ofs = '1;
            else
                ofs = $urandom;
            if (phase == 3)
                want_slot = 1'b0;
            else if (phase < 3 || phase == PRESSURE_PHASE)
                want_slot = 1'b1;
            else
                want_slot = ($urandom_range(0, 3) != 0);
            pat = make_pattern(effective_length(len_raw), want_slot);
            load_setting(pat, len_raw, ofs);

            // Short files, each with one result, while the sink holds off:
            // the block fills up and must push back on the byte channel.
            if (phase == PRESSURE_PHASE) hold_armed = 1'b1;
            if (phase == PHASES - 1) quiet_tail = 1'b1;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < BYTES_PER_PHASE)
                send_file(phase == PRESSURE_PHASE);
            stop_bytes();
        end

        settle();
        $display("summary: %0d bytes in %0d files under %0d register settings",
                 bytes_sent, files_sent, settings_used);
        $display("summary: %0d found, %0d without slot, %0d not found, long hold %0s",
                 found_cnt, no_slot_cnt, not_found_cnt, hold_seen ? "done" : "missed");
        if (mismatches == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
